/* hw/rtl/can_bit_timing_solver_core_defines.svh */
// Assertion macros shared by the CAN bit timing solver RTL.
`ifndef CAN_BIT_TIMING_SOLVER_CORE_DEFINES_SVH
`define CAN_BIT_TIMING_SOLVER_CORE_DEFINES_SVH

// Checks that a condition implies another in the same cycle, outside reset.
`define CBTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cbts assertion failed");

// Checks that a condition implies another in the following cycle, outside reset.
`define CBTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cbts assertion failed");

`endif

/* hw/rtl/cbts_pkg.sv */
// Constants and timing field helpers for the CAN bit timing solver.
`timescale 1ns / 1ps
`default_nettype none

package cbts_pkg;

    localparam int CLOCK_W   = 32;
    localparam int BITRATE_W = 20;
    localparam int TQ_W      = 5;
    localparam int SPAN_W    = BITRATE_W + TQ_W;
    localparam int WORD_W    = 23;
    localparam int PRESC_W   = 10;

    localparam logic [TQ_W-1:0]    TQ_MAX       = 5'd25;
    localparam logic [TQ_W-1:0]    TQ_MIN       = 5'd8;
    localparam logic [CLOCK_W-1:0] PRESCALE_MAX = 32'd1024;
    localparam logic [3:0]         PHASE2_MAX   = 4'd8;
    localparam logic [5:0]         PHASE1_MAX   = 6'd16;
    localparam logic [3:0]         JUMP_CAP     = 4'd4;

    // Register index decoded from paddr[2].
    localparam logic REG_CLOCK_RATE = 1'b0;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Phase two is a quarter of the quanta count, held to 1..8.
    function automatic logic [3:0] phase2_of(input logic [TQ_W-1:0] tq);
        logic [3:0] p;
        p = {1'b0, tq[4:2]};
        if (p < 4'd1) begin
            p = 4'd1;
        end
        if (p > PHASE2_MAX) begin
            p = PHASE2_MAX;
        end
        return p;
    endfunction

    // Phase one takes what is left after the sync quantum and phase two.
    function automatic logic [5:0] phase1_of(input logic [TQ_W-1:0] tq);
        return {1'b0, tq} - 6'd1 - {2'b00, phase2_of(tq)};
    endfunction

    function automatic logic phase1_fits(input logic [TQ_W-1:0] tq);
        logic [5:0] p;
        p = phase1_of(tq);
        return (p != 6'd0) && (p <= PHASE1_MAX);
    endfunction

    function automatic logic [WORD_W-1:0] build_word(input logic [TQ_W-1:0]    tq,
                                                     input logic [PRESC_W-1:0] presc_m1);
        logic [3:0] ph2;
        logic [5:0] ph1;
        logic [3:0] jump;
        logic [3:0] ph2_m1;
        logic [5:0] ph1_m1;
        logic [3:0] jump_m1;
        ph2     = phase2_of(tq);
        ph1     = phase1_of(tq);
        jump    = (ph2 < JUMP_CAP) ? ph2 : JUMP_CAP;
        ph2_m1  = ph2 - 4'd1;
        ph1_m1  = ph1 - 6'd1;
        jump_m1 = jump - 4'd1;
        return {ph2_m1[2:0], ph1_m1[3:0], jump_m1[1:0], 4'b0000, presc_m1};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/can_bit_timing_solver_core.sv */
// CAN bit timing solver: searches quanta counts with one shared restoring divider.
`timescale 1ns / 1ps
`default_nettype none

`include "can_bit_timing_solver_core_defines.svh"

// Each accepted bit rate word yields one result word: a packed CAN timing word
// for the clock held in the clock rate register, or a failure status with a zero
// word. Quanta counts from 25 down to 8 are tried in turn; each trial forms
// bitrate times count in the multiply state, then runs a 32-step restoring
// divider (one quotient bit per cycle) and ends in the check state. A zero
// clock or zero bit rate goes straight to the finish state; otherwise the
// search stops at the first passing count or after all 18 counts. A result
// waits in the finish state while the previous one is still in the output
// register, and s_ready stays low until it is loaded there. A finished result
// waits in the output register, and the next word is accepted while it waits.
module can_bit_timing_solver_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [cbts_pkg::BITRATE_W-1:0]  s_bitrate,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_status,
    output logic      [cbts_pkg::WORD_W-1:0]     m_timing_word
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    logic [cbts_pkg::CLOCK_W-1:0]        clock_rate_reg;
    logic [cbts_pkg::BITRATE_W-1:0]      rate_reg, rate_next;
    logic [cbts_pkg::TQ_W-1:0]           tq_reg, tq_next;
    logic [cbts_pkg::SPAN_W-1:0]         span_reg, span_next;
    logic [cbts_pkg::SPAN_W-1:0]         rem_reg, rem_next;
    logic [cbts_pkg::CLOCK_W-1:0]        quo_reg, quo_next;
    logic [4:0]                          bit_cnt_reg, bit_cnt_next;
    logic                                res_status_reg, res_status_next;
    logic [cbts_pkg::WORD_W-1:0]         res_word_reg, res_word_next;
    logic                                m_valid_reg, m_valid_next;
    logic                                m_status_reg, m_status_next;
    logic [cbts_pkg::WORD_W-1:0]         m_word_reg, m_word_next;

    logic                                cfg_write;
    logic [cbts_pkg::SPAN_W:0]           rem_shift;
    logic                                sub_ok;
    logic [cbts_pkg::SPAN_W:0]           rem_diff;
    logic                                trial_ok;
    logic [cbts_pkg::PRESC_W-1:0]        presc_m1;
    logic                                out_free;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == cbts_pkg::REG_CLOCK_RATE);
    assign prdata    = (paddr[2] == cbts_pkg::REG_CLOCK_RATE) ? clock_rate_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_rate_reg <= '0;
        end else if (cfg_write) begin
            clock_rate_reg <= pwdata;
        end
    end

    // Shared divider step: shift in one dividend bit, subtract the span if it fits.
    assign rem_shift = {rem_reg, quo_reg[cbts_pkg::CLOCK_W-1]};
    assign sub_ok    = rem_shift >= {1'b0, span_reg};
    assign rem_diff  = rem_shift - {1'b0, span_reg};

    assign trial_ok  = (quo_reg != '0) && (quo_reg <= cbts_pkg::PRESCALE_MAX)
                       && (rem_reg == '0) && cbts_pkg::phase1_fits(tq_reg);
    assign presc_m1  = quo_reg[cbts_pkg::PRESC_W-1:0] - cbts_pkg::PRESC_W'(1);

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        rate_next       = rate_reg;
        tq_next         = tq_reg;
        span_next       = span_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        bit_cnt_next    = bit_cnt_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_word_next     = m_word_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rate_next = s_bitrate;
                    tq_next   = cbts_pkg::TQ_MAX;
                    if ((s_bitrate == '0) || (clock_rate_reg == '0)) begin
                        res_status_next = cbts_pkg::STATUS_FAIL;
                        res_word_next   = '0;
                        state_next      = ST_FINISH;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                span_next    = cbts_pkg::SPAN_W'(rate_reg) * cbts_pkg::SPAN_W'(tq_reg);
                rem_next     = '0;
                quo_next     = clock_rate_reg;
                bit_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                // The remainder stays below the span, so it fits the span width.
                rem_next     = sub_ok ? rem_diff[cbts_pkg::SPAN_W-1:0]
                                      : rem_shift[cbts_pkg::SPAN_W-1:0];
                quo_next     = {quo_reg[cbts_pkg::CLOCK_W-2:0], sub_ok};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (trial_ok) begin
                    res_status_next = cbts_pkg::STATUS_OK;
                    res_word_next   = cbts_pkg::build_word(tq_reg, presc_m1);
                    state_next      = ST_FINISH;
                end else if (tq_reg == cbts_pkg::TQ_MIN) begin
                    res_status_next = cbts_pkg::STATUS_FAIL;
                    res_word_next   = '0;
                    state_next      = ST_FINISH;
                end else begin
                    tq_next    = tq_reg - 5'd1;
                    state_next = ST_MUL;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_word_next   = res_word_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tq_reg      <= cbts_pkg::TQ_MAX;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tq_reg      <= tq_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rate_reg       <= rate_next;
        span_reg       <= span_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        m_status_reg   <= m_status_next;
        m_word_reg     <= m_word_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_timing_word = m_word_reg;

    `CBTS_ASSERT_SAME(a_fail_word_zero,
                      m_valid && (m_status == cbts_pkg::STATUS_FAIL),
                      m_timing_word == '0)
    `CBTS_ASSERT_SAME(a_gap_bits_zero, m_valid, m_timing_word[13:10] == 4'b0000)
    `CBTS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `CBTS_ASSERT_SAME(a_tq_in_range,
                      state_reg != ST_IDLE,
                      (tq_reg >= cbts_pkg::TQ_MIN) && (tq_reg <= cbts_pkg::TQ_MAX))

endmodule

`default_nettype wire
